// ===== rtl/swr_pkg.sv =====
// Shared widths, constants, codes and divider handshake types for the SWR sweep statistics core.
// No dependencies; compile first.
package swr_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int FWD_W       = 10;
  localparam int FRAC_W      = 8;
  localparam int RATIO_W     = 18;
  localparam int LIMIT_W     = 18;
  localparam int GRADE_W     = 2;
  localparam int SWR_CAP_VAL = 255744;

  localparam int COUNT_W     = $clog2(MAX_POINTS + 1);
  localparam int SUM_W       = $clog2(64'(MAX_POINTS) * 64'(SWR_CAP_VAL) + 64'd1);
  localparam int RATIO_NUM_W = FWD_W + 1 + FRAC_W;
  localparam int DIV_W       = (SUM_W > RATIO_NUM_W) ? SUM_W : RATIO_NUM_W;
  localparam int DIVISOR_W   = (COUNT_W > FWD_W) ? COUNT_W : FWD_W;
  localparam int STEP_W      = $clog2(DIV_W + 1);

  localparam logic [RATIO_W-1:0] SWR_CAP    = RATIO_W'(SWR_CAP_VAL);
  localparam logic [RATIO_W-1:0] MIN_RESET  = '1;
  localparam logic [LIMIT_W-1:0] GOOD_RESET = LIMIT_W'(333);
  localparam logic [LIMIT_W-1:0] FAIR_RESET = LIMIT_W'(410);

  localparam logic [STEP_W-1:0] RATIO_STEPS = STEP_W'(RATIO_NUM_W);
  localparam logic [STEP_W-1:0] AVG_STEPS   = STEP_W'(DIV_W);

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GOOD_LIMIT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_FAIR_LIMIT = CFG_INDEX_W'(1);

  localparam logic [GRADE_W-1:0] GRADE_GOOD = GRADE_W'(0);
  localparam logic [GRADE_W-1:0] GRADE_FAIR = GRADE_W'(1);
  localparam logic [GRADE_W-1:0] GRADE_POOR = GRADE_W'(2);

  typedef struct packed {
    logic                 start;
    logic [STEP_W-1:0]    steps;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } swr_div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DIV_W-1:0] quotient;
  } swr_div_rsp_t;

endpackage

// ===== rtl/swr_if.sv =====
// Valid/ready channel interfaces: detector samples in, results out, register writes.
// Depends on swr_pkg.
interface swr_sample_if import swr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FWD_W-1:0] forward_level;
  logic [FWD_W-1:0] reverse_level;
  logic             last_point;

  modport source(output valid, forward_level, reverse_level, last_point, input ready);
  modport sink(input valid, forward_level, reverse_level, last_point, output ready);
endinterface

interface swr_result_if import swr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RATIO_W-1:0] ratio;
  logic               sweep_done;
  logic [RATIO_W-1:0] ratio_min;
  logic [RATIO_W-1:0] ratio_avg;
  logic [RATIO_W-1:0] ratio_max;
  logic [GRADE_W-1:0] grade;

  modport source(output valid, ratio, sweep_done, ratio_min, ratio_avg, ratio_max, grade,
                 input ready);
  modport sink(input valid, ratio, sweep_done, ratio_min, ratio_avg, ratio_max, grade,
               output ready);
endinterface

interface swr_cfg_if import swr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [LIMIT_W-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/swr_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, step count set per request.
// Depends on swr_pkg.
module swr_divider import swr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  swr_div_req_t req,
  output swr_div_rsp_t rsp
);

  logic [DIV_W-1:0]     quo;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] divisor;
  logic [STEP_W-1:0]    steps;
  logic                 busy;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;

  assign trial = {rem, quo[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      steps <= req.steps;
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      if (!diff[DIVISOR_W]) begin
        rem <= diff[DIVISOR_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIVISOR_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.quotient = quo;

endmodule

// ===== rtl/swr_sweep_statistics_core.sv =====
// Top level of the SWR sweep statistics core: FSM, accumulators, limit registers, output register.
// Depends on swr_pkg, swr_if and swr_divider.
//
// Takes one forward/reverse detector pair per beat and returns one result beat with the
// point's SWR in Q10.8 ((fwd+rev)/(fwd-rev), truncated, 999.0 when rev >= fwd or on overflow).
// On a beat marked last_point the result also carries the sweep minimum, truncated mean,
// maximum and a grade against good_limit/fair_limit, and the accumulators clear. All
// division runs through one bit-serial divider, one quotient bit per cycle: a point passes
// the ratio division (skipped when rev >= fwd) and accumulation, a last point then a second
// division for the mean. One point is in flight at a time; the next beat is taken once the
// result sits in the output register. Register writes are accepted every cycle.
module swr_sweep_statistics_core import swr_pkg::*; (
  input  logic clk,
  input  logic rst,
  swr_sample_if.sink   samples,
  swr_result_if.source results,
  swr_cfg_if.sink      cfg
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RATIO = 5'b00010,
    ST_ACCUM = 5'b00100,
    ST_AVG   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [LIMIT_W-1:0] good_limit, fair_limit;
  logic [RATIO_W-1:0] run_min, run_max, run_min_next, run_max_next;
  logic [SUM_W-1:0]   run_sum, run_sum_next;
  logic [COUNT_W-1:0] point_count, point_count_next;
  logic [RATIO_W-1:0] ratio;
  logic               last_q;

  swr_div_req_t div_req;
  swr_div_rsp_t div_rsp;

  logic                   in_beat, take, out_free, emit;
  logic                   fwd_gt_rev;
  logic [FWD_W:0]         level_sum;
  logic [RATIO_NUM_W-1:0] ratio_num;
  logic [RATIO_NUM_W-1:0] ratio_quo;
  logic [RATIO_W-1:0]     ratio_sat;
  logic [RATIO_W-1:0]     avg;
  logic [GRADE_W-1:0]     grade;

  swr_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign samples.ready = (state == ST_IDLE);
  assign in_beat       = samples.valid && samples.ready;
  assign fwd_gt_rev    = samples.forward_level > samples.reverse_level;
  assign level_sum     = {1'b0, samples.forward_level} + {1'b0, samples.reverse_level};
  assign ratio_num     = {level_sum, {FRAC_W{1'b0}}};

  assign ratio_quo = div_rsp.quotient[RATIO_NUM_W-1:0];
  assign ratio_sat = (ratio_quo > RATIO_NUM_W'(SWR_CAP)) ? SWR_CAP : ratio_quo[RATIO_W-1:0];

  always_comb begin
    div_req.start = (in_beat && fwd_gt_rev) || (state == ST_ACCUM && last_q);
    if (state == ST_ACCUM) begin
      div_req.steps    = AVG_STEPS;
      div_req.dividend = DIV_W'(run_sum_next);
      div_req.divisor  = DIVISOR_W'(point_count_next);
    end else begin
      div_req.steps    = RATIO_STEPS;
      div_req.dividend = DIV_W'(ratio_num) << (DIV_W - RATIO_NUM_W);
      div_req.divisor  = DIVISOR_W'(samples.forward_level - samples.reverse_level);
    end
  end

  // statistics update, capped at MAX_POINTS
  assign take = point_count < COUNT_W'(MAX_POINTS);

  always_comb begin
    run_min_next     = run_min;
    run_max_next     = run_max;
    run_sum_next     = run_sum;
    point_count_next = point_count;
    if (take) begin
      if (ratio < run_min) begin
        run_min_next = ratio;
      end
      if (ratio > run_max) begin
        run_max_next = ratio;
      end
      run_sum_next     = run_sum + SUM_W'(ratio);
      point_count_next = point_count + COUNT_W'(1);
    end
  end

  assign avg = div_rsp.quotient[RATIO_W-1:0];

  always_comb begin
    priority if (avg < good_limit) begin
      grade = GRADE_GOOD;
    end else if (avg < fair_limit) begin
      grade = GRADE_FAIR;
    end else begin
      grade = GRADE_POOR;
    end
  end

  assign out_free = !results.valid || results.ready;
  assign emit     = (state == ST_EMIT) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          state_next = fwd_gt_rev ? ST_RATIO : ST_ACCUM;
        end
      end
      ST_RATIO: begin
        if (!div_rsp.busy) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        state_next = last_q ? ST_AVG : ST_EMIT;
      end
      ST_AVG: begin
        if (!div_rsp.busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      last_q <= samples.last_point;
      if (!fwd_gt_rev) begin
        ratio <= SWR_CAP;
      end
    end else if (state == ST_RATIO && !div_rsp.busy) begin
      ratio <= ratio_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min     <= MIN_RESET;
      run_max     <= '0;
      run_sum     <= '0;
      point_count <= '0;
    end else if (state == ST_ACCUM) begin
      run_min     <= run_min_next;
      run_max     <= run_max_next;
      run_sum     <= run_sum_next;
      point_count <= point_count_next;
    end else if (emit && last_q) begin
      run_min     <= MIN_RESET;
      run_max     <= '0;
      run_sum     <= '0;
      point_count <= '0;
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      good_limit <= GOOD_RESET;
      fair_limit <= FAIR_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_GOOD_LIMIT: good_limit <= cfg.data;
        CFG_FAIR_LIMIT: fair_limit <= cfg.data;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      results.ratio      <= ratio;
      results.sweep_done <= last_q;
      results.ratio_min  <= last_q ? run_min : '0;
      results.ratio_avg  <= last_q ? avg : '0;
      results.ratio_max  <= last_q ? run_max : '0;
      results.grade      <= last_q ? grade : GRADE_GOOD;
    end
  end

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    point_count <= COUNT_W'(MAX_POINTS))
    else $error("point count above capacity");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    point_count != '0 |-> run_min <= run_max)
    else $error("running minimum above maximum");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (emit && last_q) |=> (point_count == '0 && run_sum == '0))
    else $error("accumulators not cleared after last point");

  a_stats_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.sweep_done) |->
      (results.ratio_min == '0 && results.ratio_max == '0 && results.grade == GRADE_GOOD))
    else $error("statistics fields set on an ordinary point");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for swr_sweep_statistics_core: directed and random detector sweeps with
// a scoreboard that predicts per-point SWR and the sweep statistics, plus limit writes.
// Depends on swr_pkg, swr_if and the core RTL.
`timescale 1ns / 100ps

module tb;
  import swr_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 80;
  localparam int RANDOM_ITEMS = 850;
  localparam int RANDOM_PHASES = 6;
  localparam longint TIMEOUT_NS = 16_000_000;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = CFG_INDEX_W'(3);

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic               sweep_done;
    logic [RATIO_W-1:0] ratio_min;
    logic [RATIO_W-1:0] ratio_avg;
    logic [RATIO_W-1:0] ratio_max;
    logic [GRADE_W-1:0] grade;
  } swr_beat_t;

  class swr_stats_board;
    logic [LIMIT_W-1:0] good_lim;
    logic [LIMIT_W-1:0] fair_lim;
    logic [RATIO_W-1:0] run_min;
    logic [RATIO_W-1:0] run_max;
    logic [27:0]        run_sum;
    logic [10:0]        points;
    swr_beat_t          predicted_beats[$];
    int mismatches;
    int beats_seen;
    int sweeps_closed;
    int capped_points;
    int beyond_capacity;
    int limit_writes;
    int spare_writes;
    int grade_seen[3];

    function new();
      good_lim = GOOD_RESET;
      fair_lim = FAIR_RESET;
      clear_run();
    endfunction

    function void clear_run();
      run_min = MIN_RESET;
      run_max = '0;
      run_sum = '0;
      points  = '0;
    endfunction

    function int pending();
      return predicted_beats.size();
    endfunction

    function logic [RATIO_W-1:0] point_swr(logic [FWD_W-1:0] fwd, logic [FWD_W-1:0] rev);
      int unsigned q;
      if (rev >= fwd) return SWR_CAP;
      q = ((32'(fwd) + 32'(rev)) << FRAC_W) / (32'(fwd) - 32'(rev));
      return (q > 32'(SWR_CAP)) ? SWR_CAP : q[RATIO_W-1:0];
    endfunction

    function void set_limit(logic [CFG_INDEX_W-1:0] idx, logic [LIMIT_W-1:0] val);
      limit_writes++;
      case (idx)
        CFG_GOOD_LIMIT: good_lim = val;
        CFG_FAIR_LIMIT: fair_lim = val;
        default: spare_writes++;
      endcase
    endfunction

    function void note_sample(logic [FWD_W-1:0] fwd, logic [FWD_W-1:0] rev, logic last);
      swr_beat_t          want;
      logic [RATIO_W-1:0] r;
      int unsigned        avg;
      want = '0;
      r = point_swr(fwd, rev);
      if (r == SWR_CAP) capped_points++;
      if (int'(points) < MAX_POINTS) begin
        if (r < run_min) run_min = r;
        if (r > run_max) run_max = r;
        run_sum += r;
        points++;
      end else begin
        beyond_capacity++;
      end
      want.ratio = r;
      if (last) begin
        avg = (points == 0) ? 0 : 32'(run_sum) / 32'(points);
        want.sweep_done = 1'b1;
        want.ratio_min  = run_min;
        want.ratio_avg  = avg[RATIO_W-1:0];
        want.ratio_max  = run_max;
        if (avg < good_lim) want.grade = GRADE_GOOD;
        else if (avg < fair_lim) want.grade = GRADE_FAIR;
        else want.grade = GRADE_POOR;
        grade_seen[want.grade]++;
        sweeps_closed++;
        clear_run();
      end
      predicted_beats.push_back(want);
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      if (mismatches <= 20)
        $display("MISMATCH beat %0d %s: got %0d, want %0d", beats_seen, what, got, want);
    endtask

    task check_result(swr_beat_t got);
      swr_beat_t want;
      beats_seen++;
      if (predicted_beats.size() == 0) begin
        report_mismatch("result with nothing pending, ratio", got.ratio, 0);
        return;
      end
      want = predicted_beats.pop_front();
      if (got.ratio !== want.ratio) report_mismatch("ratio", got.ratio, want.ratio);
      if (got.sweep_done !== want.sweep_done)
        report_mismatch("sweep_done", got.sweep_done, want.sweep_done);
      if (got.ratio_min !== want.ratio_min)
        report_mismatch("ratio_min", got.ratio_min, want.ratio_min);
      if (got.ratio_avg !== want.ratio_avg)
        report_mismatch("ratio_avg", got.ratio_avg, want.ratio_avg);
      if (got.ratio_max !== want.ratio_max)
        report_mismatch("ratio_max", got.ratio_max, want.ratio_max);
      if (got.grade !== want.grade) report_mismatch("grade", got.grade, want.grade);
    endtask

    task check_drained();
      if (predicted_beats.size() != 0)
        report_mismatch("results never delivered", predicted_beats.size(), 0);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   src_steady;
  bit   sink_steady;
  bit   hold_req;
  int   items_sent;

  swr_stats_board sb = new();

  swr_sample_if smp();
  swr_result_if res();
  swr_cfg_if    cfg_bus();

  swr_sweep_statistics_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (smp),
    .results (res),
    .cfg     (cfg_bus)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic int gap_len(bit steady);
    int p;
    if (steady) return 0;
    p = $urandom_range(99, 0);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(16, 4);
    return $urandom_range(90, 30);
  endfunction

  always @(posedge clk) begin : watch_results
    swr_beat_t seen;
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      seen.ratio      = res.ratio;
      seen.sweep_done = res.sweep_done;
      seen.ratio_min  = res.ratio_min;
      seen.ratio_avg  = res.ratio_avg;
      seen.ratio_max  = res.ratio_max;
      seen.grade      = res.grade;
      sb.check_result(seen);
    end
  end

  // result sink: random backpressure, one long hold-off on request
  initial begin : result_sink
    int idle;
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        idle = gap_len(sink_steady);
        if (idle > 0) begin
          res.ready <= 1'b0;
          repeat (idle) @(negedge clk);
        end
        res.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // all driving tasks start and end just after a falling edge
  task automatic send_point(input logic [FWD_W-1:0] fwd, input logic [FWD_W-1:0] rev,
                            input logic last);
    int gap;
    gap = gap_len(src_steady);
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp.valid         <= 1'b1;
    smp.forward_level <= fwd;
    smp.reverse_level <= rev;
    smp.last_point    <= last;
    do @(posedge clk); while (smp.ready !== 1'b1);
    sb.note_sample(fwd, rev, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic idle_source();
    smp.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    sb.set_limit(idx, val);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_limits(input int good, input int fair);
    idle_source();
    drain();
    cfg_write(CFG_GOOD_LIMIT, LIMIT_W'(good));
    cfg_write(CFG_FAIR_LIMIT, LIMIT_W'(fair));
  endtask

  task automatic run_sweeps(input int n_items);
    int sent, len, m, pick, fwd, rev;
    bit clean;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99, 0);
      if (pick < 5) len = 1;
      else if (pick < 85) len = $urandom_range(12, 2);
      else len = $urandom_range(40, 13);
      clean = ($urandom_range(99, 0) < 60);
      m = $urandom_range(120, 0);
      for (int i = 0; i < len; i++) begin
        pick = clean ? 0 : $urandom_range(99, 0);
        if (pick < 75) begin
          fwd = $urandom_range(1023, 1);
          rev = (fwd * (m + $urandom_range(8, 0))) >> 8;
        end else if (pick < 85) begin
          fwd = $urandom_range(1023, 0);
          rev = $urandom_range(1023, fwd);
        end else if (pick < 92) begin
          fwd = $urandom_range(1023, 1);
          rev = fwd - 1;
        end else begin
          fwd = $urandom_range(1023, 0);
          rev = $urandom_range(1023, 0);
        end
        send_point(FWD_W'(fwd), FWD_W'(rev), i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int fwd, rev, good;
    rst = 1'b1;
    smp.valid = 1'b0;
    smp.forward_level = '0;
    smp.reverse_level = '0;
    smp.last_point = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_GOOD_LIMIT;
    cfg_bus.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corner points under reset limits
    send_point(10'd0, 10'd0, 1'b0);
    send_point(10'd1023, 10'd0, 1'b0);
    send_point(10'd1, 10'd0, 1'b0);
    send_point(10'd1023, 10'd1023, 1'b0);
    send_point(10'd0, 10'd1023, 1'b0);
    send_point(10'd500, 10'd499, 1'b0);
    send_point(10'd501, 10'd500, 1'b0);
    send_point(10'd1023, 10'd1022, 1'b0);
    send_point(10'd1023, 10'd511, 1'b1);
    send_point(10'd1000, 10'd50, 1'b1);
    send_point(10'd1000, 10'd184, 1'b1);

    set_limits(256, 255744);
    cfg_write(CFG_SPARE_A, '1);
    cfg_write(CFG_SPARE_B, '0);
    send_point(10'd1000, 10'd184, 1'b0);
    send_point(10'd0, 10'd0, 1'b1);

    // fair limit below good limit: good wins
    set_limits(600, 300);
    send_point(10'd1000, 10'd184, 1'b1);
    send_point(10'd1000, 10'd500, 1'b1);

    // sweep past capacity; the trailing points must not touch the statistics
    set_limits(333, 410);
    src_steady = 1'b1;
    sink_steady = 1'b1;
    for (int i = 0; i < MAX_POINTS; i++) begin
      fwd = $urandom_range(1023, 64);
      rev = (fwd * $urandom_range(120, 8)) >> 8;
      send_point(FWD_W'(fwd), FWD_W'(rev), 1'b0);
    end
    send_point(10'd1023, 10'd0, 1'b0);
    send_point(10'd0, 10'd0, 1'b0);
    send_point(10'd1023, 10'd0, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_limits(GOOD_RESET, FAIR_RESET);
        1: begin
          good = $urandom_range(600, 256);
          set_limits(good, good + $urandom_range(400, 0));
        end
        2: set_limits(256, 255744);
        3: set_limits(255744, 255744);
        4: begin
          good = $urandom_range(900, 400);
          set_limits(good, $urandom_range(good, 256));
        end
        default: set_limits($urandom_range(255744, 256), $urandom_range(255744, 256));
      endcase
      src_steady = (p == 2) || (p == 4);
      sink_steady = (p == 3) || (p == 4);
      if (p == 1) hold_req = 1'b1;
      if (p == 2) begin
        run_sweeps(RANDOM_ITEMS / RANDOM_PHASES / 2);
        idle_source();
        drain();
        run_sweeps(RANDOM_ITEMS / RANDOM_PHASES / 2);
      end else begin
        run_sweeps(RANDOM_ITEMS / RANDOM_PHASES);
      end
    end

    idle_source();
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    sb.check_drained();

    $display("Run covered %0d points in %0d sweeps, %0d capped ratios, %0d past capacity",
             items_sent, sb.sweeps_closed, sb.capped_points, sb.beyond_capacity);
    $display("Grades good/fair/poor %0d/%0d/%0d, %0d limit writes (%0d to unused indexes)",
             sb.grade_seen[0], sb.grade_seen[1], sb.grade_seen[2], sb.limit_writes,
             sb.spare_writes);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/swr_pkg.sv
rtl/swr_if.sv
rtl/swr_divider.sv
rtl/swr_sweep_statistics_core.sv
tb/sv/tb.sv
